@@ hdl/lksd_pkg.sv @@
// shared types and constants for the key slot directory
package lksd_pkg;

  localparam int KEY_W  = 8;
  localparam int SLOT_W = 3;
  localparam int FREQ_W = 16;

  // request kinds
  localparam logic KIND_LEARN  = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  // reset value of the reserved key register
  localparam logic [KEY_W-1:0] RESERVED_KEY_RST = 8'hFF;

  // one directory entry as held in the table ram
  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [SLOT_W-1:0] slot;
    logic [FREQ_W-1:0] freq;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // verdict of the shared compare unit for the entry under test
  typedef struct packed {
    logic valid;
    logic hit;
  } match_t;

endpackage

@@ hdl/lksd_ram.sv @@
// generic single write port ram with registered read
module lksd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ hdl/lksd_match.sv @@
// shared compare unit: checks one entry against the request key
module lksd_match #(
  parameter int IDX_W = 3,
  parameter int CNT_W = 4
) (
  input  logic [IDX_W-1:0]          idx,
  input  logic [CNT_W-1:0]          count,
  input  logic [lksd_pkg::KEY_W-1:0] req_key,
  input  lksd_pkg::entry_t          entry,
  output lksd_pkg::match_t          result
);

  logic [CNT_W-1:0] idx_ext;

  // entries below the fill count hold written data
  assign idx_ext       = CNT_W'(idx);
  assign result.valid  = (idx_ext < count);
  assign result.hit    = result.valid && (entry.key == req_key);

endmodule

@@ hdl/lru_key_slot_directory_top.sv @@
// most-recent-first key directory with slot assignment, top level
//
//  channel | direction | handshake           | beat
//  in_     | input     | in_valid / in_stall | kind, key, frequency
//  out_    | output    | out_valid/out_stall | accepted, found, slot, entry_frequency
//  cfg_    | input     | cfg_valid/cfg_ready | reserved key write data
//
// one item at a time; the table ram gives one entry per cycle to the compare unit
// lookup: compare walk, then result state; learn: compare walk, front write, then
// result state; rejected learn: straight to the result state
// synchronous active-low reset empties the table at once through the fill count
// a result waits in the output register while out_stall is high; the block holds
// in_stall high until its result has moved into that register
module lru_key_slot_directory_top #(
  parameter int ENTRIES = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // request channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_kind,
  input  logic [lksd_pkg::KEY_W-1:0]    in_key,
  input  logic [lksd_pkg::FREQ_W-1:0]   in_frequency,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_accepted,
  output logic                          out_found,
  output logic [lksd_pkg::SLOT_W-1:0]   out_slot,
  output logic [lksd_pkg::FREQ_W-1:0]   out_entry_frequency,
  // configuration channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lksd_pkg::KEY_W-1:0]    cfg_data
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ENTRIES);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CMP  = 2'd1;
  localparam logic [1:0] ST_WR0  = 2'd2;
  localparam logic [1:0] ST_RES  = 2'd3;

  logic [1:0]                   state_r, state_nxt;
  logic [IDX_W-1:0]             idx_r, idx_nxt;
  logic [CNT_W-1:0]             count_r, count_nxt;
  logic [lksd_pkg::KEY_W-1:0]   reserved_key_r;
  logic                         op_kind_r;
  logic [lksd_pkg::KEY_W-1:0]   op_key_r;
  logic [lksd_pkg::FREQ_W-1:0]  op_freq_r;
  lksd_pkg::entry_t             carry_r, carry_nxt;
  logic [lksd_pkg::SLOT_W-1:0]  new_slot_r, new_slot_nxt;
  logic                         found_r, found_nxt;
  logic                         res_acc_r, res_acc_nxt;
  logic                         res_found_r, res_found_nxt;
  logic [lksd_pkg::SLOT_W-1:0]  res_slot_r, res_slot_nxt;
  logic [lksd_pkg::FREQ_W-1:0]  res_freq_r, res_freq_nxt;
  logic                         out_valid_r;
  logic                         out_acc_r, out_found_r;
  logic [lksd_pkg::SLOT_W-1:0]  out_slot_r;
  logic [lksd_pkg::FREQ_W-1:0]  out_freq_r;

  logic                         in_take, out_load;
  logic [IDX_W-1:0]             idx_inc;
  logic                         wr_en;
  logic [IDX_W-1:0]             wr_addr;
  lksd_pkg::entry_t             wr_data;
  logic [IDX_W-1:0]             rd_addr;
  lksd_pkg::entry_t             rd_entry;
  logic [lksd_pkg::ENTRY_W-1:0] rd_bits;
  lksd_pkg::match_t             match;

  // handshakes
  assign in_stall  = (state_r != ST_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = (state_r == ST_IDLE);
  assign out_load  = (state_r == ST_RES) && (!out_valid_r || !out_stall);
  assign idx_inc   = idx_r + 1'b1;

  // table ram and shared compare unit
  assign rd_addr  = (state_r == ST_CMP) ? idx_inc : '0;
  assign rd_entry = lksd_pkg::entry_t'(rd_bits);

  lksd_ram #(
    .WIDTH (lksd_pkg::ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (1'b1),
    .rd_addr (rd_addr),
    .rd_data (rd_bits)
  );

  lksd_match #(
    .IDX_W (IDX_W),
    .CNT_W (CNT_W)
  ) u_match (
    .idx     (idx_r),
    .count   (count_r),
    .req_key (op_key_r),
    .entry   (rd_entry),
    .result  (match)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    count_nxt     = count_r;
    carry_nxt     = carry_r;
    new_slot_nxt  = new_slot_r;
    found_nxt     = found_r;
    res_acc_nxt   = res_acc_r;
    res_found_nxt = res_found_r;
    res_slot_nxt  = res_slot_r;
    res_freq_nxt  = res_freq_r;
    wr_en         = 1'b0;
    wr_addr       = idx_r;
    wr_data       = carry_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          idx_nxt       = '0;
          found_nxt     = 1'b0;
          res_acc_nxt   = 1'b0;
          res_found_nxt = 1'b0;
          res_slot_nxt  = '0;
          res_freq_nxt  = '0;
          if ((in_kind == lksd_pkg::KIND_LEARN) && (in_key == reserved_key_r)) begin
            state_nxt = ST_RES;
          end else begin
            state_nxt = ST_CMP;
          end
        end
      end
      ST_CMP: begin
        if (op_kind_r == lksd_pkg::KIND_LOOKUP) begin
          if (match.hit) begin
            res_acc_nxt   = 1'b1;
            res_found_nxt = 1'b1;
            res_slot_nxt  = rd_entry.slot;
            res_freq_nxt  = rd_entry.freq;
            state_nxt     = ST_RES;
          end else if (!match.valid || (idx_r == LAST_IDX)) begin
            state_nxt = ST_RES;
          end else begin
            idx_nxt = idx_inc;
          end
        end else begin
          // shift the carried entry down one place; the front is written last
          wr_en = (idx_r != '0);
          if (!match.valid) begin
            count_nxt    = count_r + 1'b1;
            new_slot_nxt = lksd_pkg::SLOT_W'(idx_r);
            state_nxt    = ST_WR0;
          end else if (match.hit) begin
            found_nxt    = 1'b1;
            new_slot_nxt = rd_entry.slot;
            state_nxt    = ST_WR0;
          end else begin
            new_slot_nxt = rd_entry.slot;
            carry_nxt    = rd_entry;
            if (idx_r == LAST_IDX) begin
              state_nxt = ST_WR0;
            end else begin
              idx_nxt = idx_inc;
            end
          end
        end
      end
      ST_WR0: begin
        wr_en         = 1'b1;
        wr_addr       = '0;
        wr_data.key   = op_key_r;
        wr_data.slot  = new_slot_r;
        wr_data.freq  = op_freq_r;
        res_acc_nxt   = 1'b1;
        res_found_nxt = found_r;
        res_slot_nxt  = new_slot_r;
        res_freq_nxt  = op_freq_r;
        state_nxt     = ST_RES;
      end
      ST_RES: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      count_r        <= '0;
      reserved_key_r <= lksd_pkg::RESERVED_KEY_RST;
      out_valid_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (cfg_valid && cfg_ready) begin
        reserved_key_r <= cfg_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // request and working registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      op_kind_r    <= in_kind;
      op_key_r     <= in_key;
      op_freq_r    <= in_frequency;
    end
    idx_r       <= idx_nxt;
    carry_r     <= carry_nxt;
    new_slot_r  <= new_slot_nxt;
    found_r     <= found_nxt;
    res_acc_r   <= res_acc_nxt;
    res_found_r <= res_found_nxt;
    res_slot_r  <= res_slot_nxt;
    res_freq_r  <= res_freq_nxt;
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_acc_r   <= res_acc_r;
      out_found_r <= res_found_r;
      out_slot_r  <= res_slot_r;
      out_freq_r  <= res_freq_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_accepted        = out_acc_r;
  assign out_found           = out_found_r;
  assign out_slot            = out_slot_r;
  assign out_entry_frequency = out_freq_r;

  // fill count never passes the table depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("fill count beyond table depth");

  // the fill count only grows, one entry per learn step
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && (count_r != $past(count_r)) |->
      (count_r == $past(count_r) + 1'b1) && ($past(state_r) == ST_CMP))
    else $error("fill count moved outside a learn step");

  // the walk index stays inside the table
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CMP) |-> (idx_r <= LAST_IDX))
    else $error("walk index out of range");

  // a key reported as present is always a stored or hit result
  a_found_acc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_found_r |-> out_acc_r)
    else $error("found result without acceptance");

endmodule

@@ bench/testbench.sv @@
// self-checking bench for the most-recent-first key slot directory
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ENTRIES     = 8;
  // cycles to let pass before a register write and at the end of the run
  localparam int SETTLE      = ENTRIES + 4;
  // cycles without any beat before the run is abandoned
  localparam int STALL_LIMIT = 2000;

  // one result beat as seen on the out_ channel
  typedef struct packed {
    logic                        accepted;
    logic                        found;
    logic [lksd_pkg::SLOT_W-1:0] slot;
    logic [lksd_pkg::FREQ_W-1:0] freq;
  } slot_result_t;

  // directory predictor plus the store of results still to arrive
  class directory_scoreboard;
    lksd_pkg::entry_t             dir_entries[ENTRIES];
    bit                           dir_valid[ENTRIES];
    logic [lksd_pkg::KEY_W-1:0]   reserved_key = lksd_pkg::RESERVED_KEY_RST;
    slot_result_t                 due_results[$];
    int                           error_count = 0;

    // move the key to the front, shifting entries down to its old place or a gap
    function slot_result_t learn_key(logic [lksd_pkg::KEY_W-1:0] key,
                                     logic [lksd_pkg::FREQ_W-1:0] freq);
      slot_result_t                res;
      lksd_pkg::entry_t            carry;
      lksd_pkg::entry_t            held;
      logic [lksd_pkg::SLOT_W-1:0] new_slot;
      bit                          hit;
      res = '0;
      if (key == reserved_key) return res;
      carry.key  = key;
      carry.slot = '0;
      carry.freq = '0;
      new_slot   = '0;
      hit        = 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
        held           = dir_entries[i];
        dir_entries[i] = carry;
        carry          = held;
        if (!dir_valid[i]) begin
          new_slot     = lksd_pkg::SLOT_W'(i);
          dir_valid[i] = 1'b1;
          break;
        end
        new_slot = held.slot;
        if (held.key == key) begin
          hit = 1'b1;
          break;
        end
      end
      // when the table was full the oldest slot falls through to here
      dir_entries[0].slot = new_slot;
      dir_entries[0].freq = freq;
      res.accepted = 1'b1;
      res.found    = hit;
      res.slot     = new_slot;
      res.freq     = freq;
      return res;
    endfunction

    // first valid entry holding the key, most recent first
    function slot_result_t find_key(logic [lksd_pkg::KEY_W-1:0] key);
      slot_result_t res;
      res = '0;
      for (int i = 0; i < ENTRIES; i++) begin
        if (dir_valid[i] && dir_entries[i].key == key) begin
          res.accepted = 1'b1;
          res.found    = 1'b1;
          res.slot     = dir_entries[i].slot;
          res.freq     = dir_entries[i].freq;
          return res;
        end
      end
      return res;
    endfunction

    function void set_reserved_key(logic [lksd_pkg::KEY_W-1:0] value);
      reserved_key = value;
    endfunction

    // accepted request beat: work out the reply it will cause
    function void note_request(logic kind, logic [lksd_pkg::KEY_W-1:0] key,
                               logic [lksd_pkg::FREQ_W-1:0] freq);
      if (kind == lksd_pkg::KIND_LEARN) due_results.push_back(learn_key(key, freq));
      else due_results.push_back(find_key(key));
    endfunction

    function void compare_field(string field, longint unsigned want, longint unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        error_count++;
      end
    endfunction

    // accepted result beat: compare with the oldest reply still due
    function void check_result(slot_result_t actual);
      slot_result_t want;
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0h", $time, actual);
        error_count++;
        return;
      end
      want = due_results.pop_front();
      compare_field("accepted", 64'(want.accepted), 64'(actual.accepted));
      compare_field("found", 64'(want.found), 64'(actual.found));
      compare_field("slot", 64'(want.slot), 64'(actual.slot));
      compare_field("entry_frequency", 64'(want.freq), 64'(actual.freq));
    endfunction
  endclass

  logic                        clk;
  logic                        rst_n        = 1'b0;
  logic                        in_valid     = 1'b0;
  logic                        in_stall;
  logic                        in_kind      = lksd_pkg::KIND_LEARN;
  logic [lksd_pkg::KEY_W-1:0]  in_key       = '0;
  logic [lksd_pkg::FREQ_W-1:0] in_frequency = '0;
  logic                        out_valid;
  logic                        out_stall    = 1'b0;
  logic                        out_accepted;
  logic                        out_found;
  logic [lksd_pkg::SLOT_W-1:0] out_slot;
  logic [lksd_pkg::FREQ_W-1:0] out_entry_frequency;
  logic                        cfg_valid    = 1'b0;
  logic                        cfg_ready;
  logic [lksd_pkg::KEY_W-1:0]  cfg_data     = '0;

  directory_scoreboard sb = new;
  int send_idle_pct  = 36;
  int recv_stall_pct = 53;
  int idle_cycles    = 0;

  lru_key_slot_directory_top #(
    .ENTRIES(ENTRIES)
  ) i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_kind            (in_kind),
    .in_key             (in_key),
    .in_frequency       (in_frequency),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_accepted       (out_accepted),
    .out_found          (out_found),
    .out_slot           (out_slot),
    .out_entry_frequency(out_entry_frequency),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_data           (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // receiver back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // beat monitor and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_request(in_kind, in_key, in_frequency);
      if (out_valid && !out_stall)
        sb.check_result({out_accepted, out_found, out_slot, out_entry_frequency});
      if (cfg_valid && cfg_ready) sb.set_reserved_key(cfg_data);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  // one request beat, with an optional gap in front of it
  task automatic send_request(logic kind, logic [lksd_pkg::KEY_W-1:0] key,
                              logic [lksd_pkg::FREQ_W-1:0] freq);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_kind      <= kind;
    in_key       <= key;
    in_frequency <= freq;
    do @(posedge clk); while (in_stall);
  endtask

  // hold off requests until every reply has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.due_results.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // reserved key register write, only with the block idle
  task automatic write_reserved_key(logic [lksd_pkg::KEY_W-1:0] value);
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // random traffic around a small pool of keys so the table fills and hits
  task automatic run_random(int count, int send_pct, int recv_pct, int reserved);
    int                          key_base;
    logic                        kind;
    logic [lksd_pkg::KEY_W-1:0]  key;
    logic [lksd_pkg::FREQ_W-1:0] freq;
    int                          pick;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    key_base = $urandom_range(0, 244);
    if (reserved < 0)
      write_reserved_key(lksd_pkg::KEY_W'(key_base + $urandom_range(0, 11)));
    else write_reserved_key(lksd_pkg::KEY_W'(reserved));
    for (int n = 0; n < count; n++) begin
      if (n == count / 2) wait_drained();
      kind = ($urandom_range(0, 99) < 55) ? lksd_pkg::KIND_LEARN : lksd_pkg::KIND_LOOKUP;
      if ($urandom_range(0, 99) < 80)
        key = lksd_pkg::KEY_W'(key_base + $urandom_range(0, 11));
      else key = lksd_pkg::KEY_W'($urandom_range(0, 255));
      pick = $urandom_range(0, 99);
      if (pick < 10) freq = '0;
      else if (pick < 20) freq = '1;
      else freq = lksd_pkg::FREQ_W'($urandom_range(0, 65535));
      send_request(kind, key, freq);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty table, reserved key, fill, eviction, hits
    send_request(lksd_pkg::KIND_LOOKUP, 8'd5, 16'h1111);
    send_request(lksd_pkg::KIND_LEARN, 8'hFF, 16'h1234);
    for (int k = 0; k < ENTRIES; k++)
      send_request(lksd_pkg::KIND_LEARN, lksd_pkg::KEY_W'(k), (k == 0) ? 16'h0000 :
                   (k == ENTRIES - 1) ? 16'hFFFF : lksd_pkg::FREQ_W'(16'h0101 * k));
    send_request(lksd_pkg::KIND_LEARN, 8'd8, 16'hA5A5);
    send_request(lksd_pkg::KIND_LEARN, 8'd4, 16'h5A5A);
    send_request(lksd_pkg::KIND_LEARN, 8'd8, 16'h0F0F);
    send_request(lksd_pkg::KIND_LOOKUP, 8'd4, 16'hFFFF);
    send_request(lksd_pkg::KIND_LOOKUP, 8'd0, 16'h0000);
    send_request(lksd_pkg::KIND_LOOKUP, 8'hFF, 16'h0000);
    send_request(lksd_pkg::KIND_LOOKUP, 8'd1, 16'h0000);

    // reserved key moved to zero: zero rejected, all-ones now storable
    write_reserved_key(8'h00);
    send_request(lksd_pkg::KIND_LEARN, 8'h00, 16'h7777);
    send_request(lksd_pkg::KIND_LEARN, 8'hFF, 16'hFFFF);
    send_request(lksd_pkg::KIND_LOOKUP, 8'hFF, 16'h0000);

    // a stored key that becomes reserved still answers lookups
    write_reserved_key(8'd4);
    send_request(lksd_pkg::KIND_LOOKUP, 8'd4, 16'h0000);
    send_request(lksd_pkg::KIND_LEARN, 8'd4, 16'h3333);

    // random phases: receiver-heavy stalls, sender-heavy gaps, then none
    run_random(530, 36, 53, -1);
    run_random(530, 53, 36, -2 + 2 + $urandom_range(0, 255));
    run_random(530, 0, 0, 255);

    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (sb.due_results.size() != 0)
      $display("%0t: %0d results never arrived", $time, sb.due_results.size());
    if (sb.error_count == 0 && sb.due_results.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
